// ===== src/chc_pkg.sv =====
// Shared types, constants and round functions for the ChaCha20 stream cipher.
`default_nettype none
package chc_pkg;

    typedef logic [31:0] t_word;
    typedef t_word [15:0] t_block;

    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE = 3'd4;

    localparam logic MODE_DATA    = 1'b0;
    localparam logic MODE_RESTART = 1'b1;

    localparam t_word SIGMA0 = 32'h6170_7865;
    localparam t_word SIGMA1 = 32'h3320_646e;
    localparam t_word SIGMA2 = 32'h7962_2d32;
    localparam t_word SIGMA3 = 32'h6b20_6574;

    typedef enum logic [1:0] {
        OP_RESTART,
        OP_DATA,
        OP_BLOCK
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic [5:0] pos;
    } t_item;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_EMIT
    } t_bstate;

    function automatic t_word rotl(input t_word v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

    // One half round: four independent quarter rounds, columns or diagonals.
    function automatic t_block half_round(input t_block w, input logic diag);
        t_block r;
        t_word  a, b, c, d;
        int     s;
        int     ib, ic, id;
        r = w;
        s = diag ? 1 : 0;
        for (int i = 0; i < 4; i++) begin
            ib = 4  + ((i + s) & 3);
            ic = 8  + ((i + 2 * s) & 3);
            id = 12 + ((i + 3 * s) & 3);
            a = w[i];
            b = w[ib];
            c = w[ic];
            d = w[id];
            a = a + b; d = rotl(d ^ a, 16);
            c = c + d; b = rotl(b ^ c, 12);
            a = a + b; d = rotl(d ^ a, 8);
            c = c + d; b = rotl(b ^ c, 7);
            r[i]  = a;
            r[ib] = b;
            r[ic] = c;
            r[id] = d;
        end
        half_round = r;
    endfunction

    function automatic logic [7:0] ks_byte(input t_block ks, input logic [5:0] pos);
        t_word w;
        w = ks[pos[5:2]];
        ks_byte = 8'(w >> {pos[1:0], 3'b000});
    endfunction

endpackage
`default_nettype wire

// ===== src/chc_in_if.sv =====
// Input word channel: valid/ready handshake with mode, data byte and call start.
`default_nettype none
interface chc_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;
    logic       first_of_call;

    modport source (output valid, output mode, output data_byte, output first_of_call,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input first_of_call,
                    output ready);
endinterface
`default_nettype wire

// ===== src/chc_out_if.sv =====
// Output word channel: valid/ready handshake with the transformed byte.
`default_nettype none
interface chc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface
`default_nettype wire

// ===== src/chc_queue.sv =====
// Short FIFO of classified words between front and back.
`default_nettype none
module chc_queue #(
    parameter int DEPTH = chc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  chc_pkg::t_item i_item,
    output logic           o_full,
    input  wire            i_pop,
    output chc_pkg::t_item o_item,
    output logic           o_valid
);
    import chc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== src/chc_front.sv =====
// Front end: accepts input words, tracks byte position, classifies each word.
`default_nettype none
module chc_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    chc_in_if.sink         i_in,
    input  wire            i_full,
    output logic           o_push,
    output chc_pkg::t_item o_item
);
    import chc_pkg::*;

    logic [5:0] r_pos, n_pos;
    logic [5:0] pos;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign pos        = i_in.first_of_call ? 6'd0 : r_pos;

    always_comb begin
        o_item.data = i_in.data_byte;
        o_item.pos  = pos;
        n_pos       = r_pos;
        if (i_in.mode == MODE_RESTART) begin
            o_item.op = OP_RESTART;
        end else begin
            o_item.op = (pos == 6'd0) ? OP_BLOCK : OP_DATA;
            if (o_push) begin
                n_pos = pos + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule
`default_nettype wire

// ===== src/chc_round.sv =====
// Round unit: one half round per cycle, then the feed-forward add into keystream.
`default_nettype none
module chc_round #(
    parameter int DOUBLE_ROUNDS = chc_pkg::DOUBLE_ROUNDS_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_start,
    input  chc_pkg::t_block i_init,
    output logic            o_done,
    output chc_pkg::t_block o_ks
);
    import chc_pkg::*;

    localparam int HALVES = 2 * DOUBLE_ROUNDS;
    localparam int HALF_W = $clog2(HALVES);

    t_block            r_work;
    t_block            r_init;
    t_block            r_ks;
    logic              r_busy;
    logic              r_final;
    logic [HALF_W-1:0] r_half;

    assign o_done = r_final;
    assign o_ks   = r_ks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_final <= 1'b0;
            r_half  <= '0;
        end else begin
            r_final <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_half <= '0;
            end else if (r_busy) begin
                r_half <= r_half + 1'b1;
                if (r_half == HALF_W'(HALVES - 1)) begin
                    r_busy  <= 1'b0;
                    r_final <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_init;
            r_init <= i_init;
        end else if (r_busy) begin
            r_work <= half_round(r_work, r_half[0]);
        end
        if (r_final) begin
            for (int i = 0; i < 16; i++) begin
                r_ks[i] <= r_work[i] + r_init[i];
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/chc_back.sv =====
// Back end: key/nonce registers, block counter, block sequencing and output register.
`default_nettype none
module chc_back #(
    parameter int DOUBLE_ROUNDS = chc_pkg::DOUBLE_ROUNDS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [chc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [chc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire                              i_q_valid,
    input  chc_pkg::t_item                   i_q_item,
    output logic                             o_pop,
    chc_out_if.source                        o_out
);
    import chc_pkg::*;

    t_bstate     r_state, n_state;
    logic [63:0] r_key [4];
    logic [63:0] r_nonce;
    logic [63:0] r_ctr;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;

    logic   out_free;
    logic   emit;
    logic   start;
    logic   ctr_clr;
    logic   ctr_inc;
    logic   rnd_done;
    t_block init;
    t_block ks;

    assign out_free       = !r_out_valid || o_out.ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;

    always_comb begin
        init[0]  = SIGMA0;
        init[1]  = SIGMA1;
        init[2]  = SIGMA2;
        init[3]  = SIGMA3;
        for (int i = 0; i < 4; i++) begin
            init[4 + 2 * i] = r_key[i][31:0];
            init[5 + 2 * i] = r_key[i][63:32];
        end
        init[12] = r_ctr[31:0];
        init[13] = r_ctr[63:32];
        init[14] = r_nonce[31:0];
        init[15] = r_nonce[63:32];
    end

    chc_round #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_round (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_init (init),
        .o_done (rnd_done),
        .o_ks   (ks)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid && i_q_item.op == OP_BLOCK) begin
                    n_state = B_RUN;
                end
            end
            B_RUN: begin
                if (rnd_done) begin
                    n_state = B_EMIT;
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        emit    = 1'b0;
        start   = 1'b0;
        ctr_clr = 1'b0;
        ctr_inc = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_item.op)
                        OP_RESTART: begin
                            o_pop   = 1'b1;
                            ctr_clr = 1'b1;
                        end
                        OP_DATA: begin
                            o_pop = out_free;
                            emit  = out_free;
                        end
                        OP_BLOCK: begin
                            start   = 1'b1;
                            ctr_inc = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            B_EMIT: begin
                o_pop = out_free;
                emit  = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_ctr       <= '0;
            r_out_valid <= 1'b0;
            r_nonce     <= '0;
            for (int i = 0; i < 4; i++) begin
                r_key[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (ctr_clr) begin
                r_ctr <= '0;
            end else if (ctr_inc) begin
                r_ctr <= r_ctr + 64'd1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_KEY0:  r_key[0] <= i_cfg_data;
                    CFG_KEY1:  r_key[1] <= i_cfg_data;
                    CFG_KEY2:  r_key[2] <= i_cfg_data;
                    CFG_KEY3:  r_key[3] <= i_cfg_data;
                    CFG_NONCE: r_nonce  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= i_q_item.data ^ ks_byte(ks, i_q_item.pos);
        end
    end

endmodule
`default_nettype wire

// ===== src/chacha20_stream_cipher.sv =====
// Top level of the ChaCha20 byte stream cipher (64-bit nonce, 64-bit counter).
//
// One byte per input word is XORed with the next keystream byte; decryption is
// the same operation. A restart word (mode 1) clears the block counter and
// gives no output. The front end takes a word every cycle while its queue has
// room; bytes inside a keystream block leave at one per cycle unless the output
// stalls. The first byte of a call and of each later 64-byte block starts a
// new block; the round unit does one half round per cycle. Key and nonce are
// to be written through the configuration port only while the block is idle,
// which the block does not enforce; they apply from the next block.
`default_nettype none
module chacha20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = chc_pkg::DOUBLE_ROUNDS_DEF,
    parameter int QUEUE_DEPTH   = chc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [chc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [chc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    chc_in_if.sink                        i_in,
    chc_out_if.source                     o_out
);
    import chc_pkg::*;

    logic  push;
    logic  full;
    logic  pop;
    logic  q_valid;
    t_item push_item;
    t_item q_item;

    chc_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_item (push_item)
    );

    chc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (push_item),
        .o_full (full),
        .i_pop  (pop),
        .o_item (q_item),
        .o_valid(q_valid)
    );

    chc_back #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
`default_nettype wire

// ===== src/chc_checker.sv =====
// Port-level assertions for the cipher top level, with their bind.
`default_nettype none
module chc_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [7:0] i_out_byte
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte))
        else $error("output word dropped or changed while stalled");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

endmodule

bind chacha20_stream_cipher chc_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_byte (o_out.out_byte)
);
`default_nettype wire

// ===== sim/chacha20_stream_cipher_chk.sv =====
`timescale 1ns / 1ps
// Checker for the ChaCha20 byte stream cipher: keystream predictor and output comparison.
module chacha20_stream_cipher_chk #(
    parameter int DOUBLE_ROUNDS = chc_pkg::DOUBLE_ROUNDS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [chc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [chc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    chc_in_if                             i_in_ch,
    chc_out_if                            i_out_ch,
    output int                            o_fail_count,
    output int                            o_pending
);
    import chc_pkg::*;

    logic [63:0] key_q [4];
    logic [63:0] nonce_q;
    logic [63:0] blk_ctr;
    t_block      ks_blk;
    logic [5:0]  ks_pos;
    logic [7:0]  cipher_q [$];
    int          mism;

    function automatic logic [31:0] rot_left(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // a, b, c, d in, packed back as {a, b, c, d}
    function automatic logic [127:0] mix_quad(input logic [31:0] a, input logic [31:0] b,
                                              input logic [31:0] c, input logic [31:0] d);
        a = a + b; d = rot_left(d ^ a, 16);
        c = c + d; b = rot_left(b ^ c, 12);
        a = a + b; d = rot_left(d ^ a, 8);
        c = c + d; b = rot_left(b ^ c, 7);
        return {a, b, c, d};
    endfunction

    function automatic t_block keystream_block(input logic [63:0] ctr);
        t_block       init;
        t_block       x;
        logic [127:0] q;
        int           ib, ic, id;
        init[0]  = SIGMA0;
        init[1]  = SIGMA1;
        init[2]  = SIGMA2;
        init[3]  = SIGMA3;
        for (int k = 0; k < 4; k++) begin
            init[4 + 2 * k] = key_q[k][31:0];
            init[5 + 2 * k] = key_q[k][63:32];
        end
        init[12] = ctr[31:0];
        init[13] = ctr[63:32];
        init[14] = nonce_q[31:0];
        init[15] = nonce_q[63:32];
        x = init;
        for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            for (int i = 0; i < 4; i++) begin
                q = mix_quad(x[i], x[4 + i], x[8 + i], x[12 + i]);
                x[i]      = q[127:96];
                x[4 + i]  = q[95:64];
                x[8 + i]  = q[63:32];
                x[12 + i] = q[31:0];
            end
            for (int i = 0; i < 4; i++) begin
                ib = 4 + ((i + 1) & 3);
                ic = 8 + ((i + 2) & 3);
                id = 12 + ((i + 3) & 3);
                q = mix_quad(x[i], x[ib], x[ic], x[id]);
                x[i]  = q[127:96];
                x[ib] = q[95:64];
                x[ic] = q[63:32];
                x[id] = q[31:0];
            end
        end
        for (int i = 0; i < 16; i++)
            x[i] = x[i] + init[i];
        return x;
    endfunction

    always @(posedge i_clk) begin : track
        logic [7:0] ks;
        logic [7:0] want;
        logic [7:0] got;
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++)
                key_q[k] = '0;
            nonce_q = '0;
            blk_ctr = '0;
            ks_pos  = '0;
            cipher_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY0:  key_q[0] = i_cfg_data;
                    CFG_KEY1:  key_q[1] = i_cfg_data;
                    CFG_KEY2:  key_q[2] = i_cfg_data;
                    CFG_KEY3:  key_q[3] = i_cfg_data;
                    CFG_NONCE: nonce_q  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                if (i_in_ch.mode == MODE_RESTART) begin
                    blk_ctr = '0;
                end else begin
                    if (i_in_ch.first_of_call)
                        ks_pos = '0;
                    if (ks_pos == 6'd0) begin
                        ks_blk  = keystream_block(blk_ctr);
                        blk_ctr = blk_ctr + 64'd1;
                    end
                    ks = 8'(ks_blk[ks_pos[5:2]] >> (8 * ks_pos[1:0]));
                    cipher_q.push_back(i_in_ch.data_byte ^ ks);
                    ks_pos = ks_pos + 6'd1;
                end
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                got = i_out_ch.out_byte;
                if (cipher_q.size() == 0) begin
                    mism++;
                    if (mism <= 10)
                        $display("unexpected out_byte %02h at %0t", got, $realtime);
                end else begin
                    want = cipher_q.pop_front();
                    if (got !== want) begin
                        mism++;
                        if (mism <= 10)
                            $display("out_byte mismatch at %0t: expected %02h got %02h",
                                     $realtime, want, got);
                    end
                end
            end
        end
        o_fail_count <= mism;
        o_pending    <= cipher_q.size();
    end

endmodule

// ===== sim/chacha20_stream_cipher_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the ChaCha20 byte stream cipher: stimulus, pacing and verdict.
module chacha20_stream_cipher_tb;
    import chc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_NONCE + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

    localparam int IDLE_CYCLES  = 64;
    localparam int RANDOM_WORDS = 1850;
    localparam int PHASES       = 5;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    calm_words = 0;

    chc_in_if  in_ch ();
    chc_out_if out_ch ();

    chacha20_stream_cipher DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    chacha20_stream_cipher_chk checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin : sink_pacing
        int calm;
        int stall;
        int r;
        calm  = 0;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (calm > 0) begin
                calm--;
                out_ch.ready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    calm = $urandom_range(50, 300);
                else if (r < 28)
                    stall = $urandom_range(1, 3);
                else if (r < 31)
                    stall = $urandom_range(10, 40);
                out_ch.ready <= (stall == 0);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm_words > 0) begin
            calm_words--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            calm_words = $urandom_range(30, 200);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(input logic m, input logic [7:0] d, input logic f);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.mode          <= m;
        in_ch.data_byte     <= d;
        in_ch.first_of_call <= f;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // hold off input until every expected byte is out, then idle a while
    task automatic drain(input int extra);
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic program_cfg(input logic [63:0] k0, input logic [63:0] k1,
                               input logic [63:0] k2, input logic [63:0] k3,
                               input logic [63:0] n);
        cfg_write(CFG_KEY0, k0);
        cfg_write(CFG_UNUSED_LO, {$urandom, $urandom});
        cfg_write(CFG_KEY1, k1);
        cfg_write(CFG_KEY2, k2);
        cfg_write(CFG_KEY3, k3);
        cfg_write(CFG_NONCE, n);
        cfg_write(CFG_UNUSED_HI, ~n);
        cfg_we <= 1'b0;
    endtask

    task automatic random_stream(input int n);
        int  sent;
        int  len;
        int  r;
        logic f;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            if (r < 7) begin
                send_word(MODE_RESTART, 8'($urandom), 1'($urandom_range(0, 1)));
                sent++;
            end else if (r < 9) begin
                drain(0);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    len = $urandom_range(1, 16);
                else if (r < 85)
                    len = $urandom_range(17, 70);
                else
                    len = $urandom_range(60, 140);
                for (int k = 0; k < len && sent < n; k++) begin
                    f = (k == 0) && ($urandom_range(0, 9) != 0);
                    if ($urandom_range(0, 99) < 3)
                        f = ~f;
                    send_word(MODE_DATA, 8'($urandom), f);
                    sent++;
                end
            end
        end
    endtask

    initial begin : stimulus
        logic [63:0] kv [4];
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= '0;
        cfg_data            <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.mode          <= MODE_DATA;
        in_ch.data_byte     <= '0;
        in_ch.first_of_call <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset key and nonce; restarts, call starts and byte extremes
        send_word(MODE_DATA, 8'h00, 1'b1);
        send_word(MODE_DATA, 8'hff, 1'b0);
        send_word(MODE_DATA, 8'h5a, 1'b0);
        send_word(MODE_RESTART, 8'hff, 1'b1);
        send_word(MODE_DATA, 8'h00, 1'b1);
        send_word(MODE_DATA, 8'hff, 1'b1);
        send_word(MODE_RESTART, 8'h00, 1'b0);
        send_word(MODE_DATA, 8'hc3, 1'b0);
        send_word(MODE_RESTART, 8'haa, 1'b0);
        send_word(MODE_RESTART, 8'h55, 1'b1);
        send_word(MODE_DATA, 8'h80, 1'b1);
        send_word(MODE_DATA, 8'h01, 1'b0);
        send_word(MODE_DATA, 8'h7f, 1'b0);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain(IDLE_CYCLES);
            case (ph)
                0: program_cfg('1, '1, '1, '1, '1);
                2: program_cfg({32'haaaaaaaa, 32'haaaaaaaa}, {32'h55555555, 32'h55555555},
                               {32'haaaaaaaa, 32'haaaaaaaa}, {32'h55555555, 32'h55555555},
                               {$urandom, $urandom});
                4: program_cfg('0, '0, '0, '0, '0);
                default: begin
                    for (int k = 0; k < 4; k++)
                        kv[k] = {$urandom, $urandom};
                    program_cfg(kv[0], kv[1], kv[2], kv[3], {$urandom, $urandom});
                end
            endcase
            random_stream(RANDOM_WORDS / PHASES);
        end

        drain(IDLE_CYCLES);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== chacha20_stream_cipher.f =====
src/chc_pkg.sv
src/chc_in_if.sv
src/chc_out_if.sv
src/chc_queue.sv
src/chc_front.sv
src/chc_round.sv
src/chc_back.sv
src/chacha20_stream_cipher.sv
src/chc_checker.sv
sim/chacha20_stream_cipher_chk.sv
sim/chacha20_stream_cipher_tb.sv
